// ===== rtl/ssca_pkg.sv =====
// ----------------------------------------------------------------------------
// Slab size-class allocator package
// Shared constants, types and size-class lookup functions.
// ----------------------------------------------------------------------------
package ssca_pkg;

    localparam int ADDR_BITS        = 16;
    localparam int PAGE_BYTES       = 4096;
    localparam int PAGE_SHIFT       = 12;
    localparam int MAX_CLASS_BYTES  = 4096;
    localparam int MIN_OBJECT_BYTES = 8;
    localparam int OBJ_BITS         = 3;
    localparam int NUM_PAGES        = 16;
    localparam int PAGE_IDX_BITS    = 4;
    localparam int NUM_LINKS        = 8192;
    localparam int LINK_IDX_BITS    = ADDR_BITS - OBJ_BITS;
    localparam int NUM_CLASSES      = 16;
    localparam int SIZE_BITS        = 17;
    localparam int TABLE_LIMIT      = 192;
    localparam int ZERO_MARK        = 16;

    localparam logic [3:0] TAG_FIRST = 4'd15;
    localparam logic [3:0] TAG_CONT  = 4'd14;
    localparam logic [3:0] TAG_LAST_CLASS = 4'd12;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOM  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Head or link entry: valid flag over an address.
    typedef logic [ADDR_BITS:0] t_link;

    // Write port of the object link memory.
    typedef struct packed {
        logic                     en;
        logic [LINK_IDX_BITS-1:0] idx;
        t_link                    data;
    } t_link_wr;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WB,
        S_CARVE,
        S_WALK,
        S_DONE
    } t_state;

    // Fixed class table for small sizes, indexed by (size-1)/8.
    function automatic logic [3:0] table_class(input logic [4:0] idx);
        logic [3:0] c;
        unique case (idx)
            5'd0:                       c = 4'd3;
            5'd1:                       c = 4'd4;
            5'd2, 5'd3:                 c = 4'd5;
            5'd4, 5'd5, 5'd6, 5'd7:     c = 4'd6;
            5'd8, 5'd9, 5'd10, 5'd11:   c = 4'd1;
            5'd12, 5'd13, 5'd14, 5'd15: c = 4'd7;
            default:                    c = 4'd2;
        endcase
        return c;
    endfunction

    // Object size of a class.
    function automatic logic [12:0] class_bytes(input logic [3:0] c);
        logic [12:0] b;
        if (c == 4'd1) begin
            b = 13'd96;
        end else if (c == 4'd2) begin
            b = 13'd192;
        end else begin
            b = 13'(1) << c;
        end
        return b;
    endfunction

endpackage

// ===== rtl/ssca_size_decode.sv =====
// ----------------------------------------------------------------------------
// Size decoder
// Maps an allocate size to its class, or to a page count for large sizes.
// ----------------------------------------------------------------------------
module ssca_size_decode (
    input  logic [ssca_pkg::SIZE_BITS-1:0] i_size,
    output logic                           o_zero,
    output logic                           o_large,
    output logic [3:0]                     o_class,
    output logic [5:0]                     o_pages
);

    logic [ssca_pkg::SIZE_BITS-1:0] w_m1;
    logic [17:0]                    w_round;
    logic [3:0]                     w_fls;

    assign w_m1    = i_size - 17'd1;
    assign w_round = {1'b0, i_size} + 18'd4095;
    assign o_zero  = (i_size == '0);
    assign o_large = (i_size > 17'(ssca_pkg::MAX_CLASS_BYTES));
    assign o_pages = w_round[17:12];

    // Highest set bit position of size-1 (one-based), over 12 bits.
    always_comb begin
        w_fls = 4'd0;
        for (int i = 0; i < 12; i++) begin
            if (w_m1[i]) begin
                w_fls = 4'(i + 1);
            end
        end
    end

    // Small sizes use the table, medium sizes the power-of-two class.
    always_comb begin
        if (i_size <= 17'(ssca_pkg::TABLE_LIMIT)) begin
            o_class = ssca_pkg::table_class(w_m1[7:3]);
        end else begin
            o_class = w_fls;
        end
    end

endmodule

// ===== rtl/ssca_link_mem.sv =====
// ----------------------------------------------------------------------------
// Object link memory
// One next-pointer per 8-byte line, one write and one registered read port.
// ----------------------------------------------------------------------------
module ssca_link_mem (
    input  logic                                i_clk,
    input  ssca_pkg::t_link_wr                  i_wr,
    input  logic [ssca_pkg::LINK_IDX_BITS-1:0]  i_rd_idx,
    output ssca_pkg::t_link                     o_rd_data
);

    ssca_pkg::t_link mem [ssca_pkg::NUM_LINKS];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.idx] <= i_wr.data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rd_data <= mem[i_rd_idx];
    end

endmodule

// ===== rtl/slab_size_class_allocator.sv =====
// ----------------------------------------------------------------------------
// Slab size-class allocator
// Allocates and frees objects by size class over a 64 KiB address space.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                  Word
//  in       sink       i_in_valid / o_in_stall    request, size, address, grant
//  out      source     o_out_valid / i_out_stall  status, address, release
//
// One request is worked at a time. A pop passes the decision, write-back and
// done states, a free push or large allocate the decision and done states.
// Carving an empty class writes one link per cycle. A large free walks one page
// per cycle. Reset clears list heads and page tags at once; the link memory has
// no reset. A stalled output word holds the next request.
module slab_size_class_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [16:0] i_req_size,
    input  logic [15:0] i_free_addr,
    input  logic        i_grant_ok,
    input  logic [15:0] i_grant_base,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_result_addr,
    output logic        o_grant_used,
    output logic        o_release_valid,
    output logic [15:0] o_release_base,
    output logic [16:0] o_release_bytes
);

    ssca_pkg::t_state r_state, n_state;

    // Request register.
    logic        r_type;
    logic [16:0] r_size;
    logic [15:0] r_faddr;
    logic        r_gok;
    logic [15:0] r_gbase;

    // State held in flops.
    ssca_pkg::t_link r_heads [ssca_pkg::NUM_CLASSES];
    logic [3:0]      r_map   [ssca_pkg::NUM_PAGES];

    // Work registers.
    ssca_pkg::t_link r_head;
    logic [12:0]     r_off;
    logic [4:0]      r_walk_p;

    // Pending result.
    logic [1:0]  r_res_status;
    logic [15:0] r_res_addr;
    logic        r_res_used;
    logic        r_res_rel;
    logic [15:0] r_res_rbase;
    logic [16:0] r_res_rbytes;

    logic              w_zero, w_large;
    logic [3:0]        w_class;
    logic [5:0]        w_pages;
    logic [12:0]       w_sz;
    logic [3:0]        w_fpage;
    logic [3:0]        w_ftag;
    logic [4:0]        w_first;
    logic [6:0]        w_end;
    logic [13:0]       w_next_off;
    logic [14:0]       w_after;
    logic              w_last;
    logic              w_out_free;
    ssca_pkg::t_link   w_rd_data;
    ssca_pkg::t_link_wr w_wr;
    logic [ssca_pkg::LINK_IDX_BITS-1:0] w_rd_idx;

    ssca_size_decode u_dec (
        .i_size  (r_size),
        .o_zero  (w_zero),
        .o_large (w_large),
        .o_class (w_class),
        .o_pages (w_pages)
    );

    ssca_link_mem u_links (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_idx  (w_rd_idx),
        .o_rd_data (w_rd_data)
    );

    assign o_in_stall = (r_state != ssca_pkg::S_IDLE);
    assign w_out_free = !o_out_valid || !i_out_stall;
    assign w_sz       = ssca_pkg::class_bytes(w_class);
    assign w_fpage    = r_faddr[15:12];
    assign w_ftag     = r_map[w_fpage];
    assign w_first    = {1'b0, r_gbase[15:12]};
    assign w_end      = 7'(w_first) + 7'(w_pages);
    assign w_next_off = 14'(r_off) + 14'(w_sz);
    assign w_after    = 15'(w_next_off) + 15'(w_sz);
    assign w_last     = (w_after > 15'(ssca_pkg::PAGE_BYTES));
    // The link of the class head is read in the decision cycle, so it is
    // ready for the write-back cycle of a pop.
    assign w_rd_idx   = r_heads[w_class][15:3];

    // Link memory writes: carve steps and free pushes.
    always_comb begin
        w_wr = '0;
        if (r_state == ssca_pkg::S_CARVE) begin
            w_wr.en   = 1'b1;
            w_wr.idx  = 13'((r_gbase + 16'(r_off)) >> ssca_pkg::OBJ_BITS);
            w_wr.data = w_last ? r_head : {1'b1, r_gbase + 16'(w_next_off)};
        end else if (r_state == ssca_pkg::S_EXEC && r_type == ssca_pkg::REQ_FREE
                     && r_faddr != 16'(ssca_pkg::ZERO_MARK) && w_ftag >= 4'd1
                     && w_ftag <= ssca_pkg::TAG_LAST_CLASS) begin
            w_wr.en   = 1'b1;
            w_wr.idx  = r_faddr[15:3];
            w_wr.data = r_heads[w_ftag];
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssca_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ssca_pkg::S_IDLE: begin
                if (i_in_valid) n_state = ssca_pkg::S_EXEC;
            end
            ssca_pkg::S_EXEC: begin
                n_state = ssca_pkg::S_DONE;
                if (r_type == ssca_pkg::REQ_ALLOC) begin
                    if (!w_zero && !w_large) begin
                        if (r_heads[w_class][16]) begin
                            n_state = ssca_pkg::S_POP_WB;
                        end else if (r_gok) begin
                            n_state = ssca_pkg::S_CARVE;
                        end
                    end
                end else if (r_faddr != 16'(ssca_pkg::ZERO_MARK)
                             && w_ftag == ssca_pkg::TAG_FIRST) begin
                    n_state = ssca_pkg::S_WALK;
                end
            end
            ssca_pkg::S_POP_WB: n_state = ssca_pkg::S_DONE;
            ssca_pkg::S_CARVE: begin
                if (w_last) n_state = ssca_pkg::S_DONE;
            end
            ssca_pkg::S_WALK: begin
                if (r_walk_p[4] || r_map[r_walk_p[3:0]] != ssca_pkg::TAG_CONT) begin
                    n_state = ssca_pkg::S_DONE;
                end
            end
            ssca_pkg::S_DONE: begin
                if (w_out_free) n_state = ssca_pkg::S_IDLE;
            end
            default: n_state = ssca_pkg::S_IDLE;
        endcase
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (r_state == ssca_pkg::S_IDLE && i_in_valid) begin
            r_type  <= i_req_type;
            r_size  <= i_req_size;
            r_faddr <= i_free_addr;
            r_gok   <= i_grant_ok;
            r_gbase <= {i_grant_base[15:12], 12'd0};
        end
    end

    // Heads and page tags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ssca_pkg::NUM_CLASSES; i++) r_heads[i] <= '0;
            for (int i = 0; i < ssca_pkg::NUM_PAGES; i++) r_map[i] <= '0;
        end else begin
            if (r_state == ssca_pkg::S_EXEC) begin
                if (r_type == ssca_pkg::REQ_ALLOC && w_large && r_gok
                    && w_end <= 7'(ssca_pkg::NUM_PAGES)) begin
                    for (int p = 0; p < ssca_pkg::NUM_PAGES; p++) begin
                        if (7'(p) >= 7'(w_first) && 7'(p) < w_end) begin
                            r_map[p] <= (5'(p) == w_first) ? ssca_pkg::TAG_FIRST
                                                          : ssca_pkg::TAG_CONT;
                        end
                    end
                end else if (w_wr.en) begin
                    r_heads[w_ftag] <= {1'b1, r_faddr};
                end
            end else if (r_state == ssca_pkg::S_POP_WB) begin
                r_heads[w_class] <= w_rd_data;
            end else if (r_state == ssca_pkg::S_CARVE && w_last) begin
                r_map[r_gbase[15:12]] <= w_class;
                r_heads[w_class] <= (r_off == '0) ? r_head
                                  : {1'b1, r_gbase + 16'(w_sz)};
            end
        end
    end

    // Work registers and pending result.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ssca_pkg::S_EXEC: begin
                r_head       <= r_heads[w_class];
                r_off        <= '0;
                r_walk_p     <= 5'(w_fpage) + 5'd1;
                r_res_status <= ssca_pkg::ST_OK;
                r_res_addr   <= '0;
                r_res_used   <= 1'b0;
                r_res_rel    <= 1'b0;
                r_res_rbase  <= '0;
                r_res_rbytes <= '0;
                if (r_type == ssca_pkg::REQ_ALLOC) begin
                    if (w_zero) begin
                        r_res_status <= ssca_pkg::ST_ZERO;
                        r_res_addr   <= 16'(ssca_pkg::ZERO_MARK);
                    end else if (w_large) begin
                        if (!r_gok || w_end > 7'(ssca_pkg::NUM_PAGES)) begin
                            r_res_status <= ssca_pkg::ST_OOM;
                        end else begin
                            r_res_addr <= r_gbase;
                            r_res_used <= 1'b1;
                        end
                    end else if (r_heads[w_class][16]) begin
                        r_res_addr <= r_heads[w_class][15:0];
                    end else if (!r_gok) begin
                        r_res_status <= ssca_pkg::ST_OOM;
                    end else begin
                        r_res_addr <= r_gbase;
                        r_res_used <= 1'b1;
                    end
                end else if (r_faddr != 16'(ssca_pkg::ZERO_MARK)
                             && w_ftag == ssca_pkg::TAG_FIRST) begin
                    r_res_rel    <= 1'b1;
                    r_res_rbase  <= {w_fpage, 12'd0};
                    r_res_rbytes <= 17'(ssca_pkg::PAGE_BYTES);
                end
            end
            ssca_pkg::S_CARVE: begin
                r_off <= w_next_off[12:0];
            end
            ssca_pkg::S_WALK: begin
                if (!r_walk_p[4] && r_map[r_walk_p[3:0]] == ssca_pkg::TAG_CONT) begin
                    r_res_rbytes <= r_res_rbytes + 17'(ssca_pkg::PAGE_BYTES);
                    r_walk_p     <= r_walk_p + 5'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == ssca_pkg::S_DONE && w_out_free) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ssca_pkg::S_DONE && w_out_free) begin
            o_status        <= r_res_status;
            o_result_addr   <= r_res_addr;
            o_grant_used    <= r_res_used;
            o_release_valid <= r_res_rel;
            o_release_base  <= r_res_rbase;
            o_release_bytes <= r_res_rbytes;
        end
    end

    // A pop write-back always follows the decision cycle.
    a_pop_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ssca_pkg::S_POP_WB |-> $past(r_state) == ssca_pkg::S_EXEC)
        else $error("pop write-back without a decision cycle");

    // Consumed pages and releases only come with an ok status.
    a_used_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_grant_used || o_release_valid) |-> o_status == ssca_pkg::ST_OK)
        else $error("grant or release reported with a failing status");

    // Carving never runs past the end of the page.
    a_carve_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ssca_pkg::S_CARVE |-> 14'(r_off) < 14'(ssca_pkg::PAGE_BYTES))
        else $error("carve offset left the page");

    // New requests are taken only from idle.
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ssca_pkg::S_EXEC |-> $past(r_state) == ssca_pkg::S_IDLE)
        else $error("request taken while busy");

endmodule

// ===== dv/tb_slab_size_class_allocator.sv =====
// ----------------------------------------------------------------------------
// Testbench for the slab size-class allocator
// Drives allocate and free words, predicts every response with a behavioral
// copy of the allocator (free lists, object links, page tags) and checks each
// output word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_slab_size_class_allocator;

    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] addr;
        logic        used;
        logic        rel_valid;
        logic [15:0] rel_base;
        logic [16:0] rel_bytes;
    } t_resp;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_req_type;
    logic [16:0] i_req_size;
    logic [15:0] i_free_addr;
    logic        i_grant_ok;
    logic [15:0] i_grant_base;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_status;
    logic [15:0] o_result_addr;
    logic        o_grant_used;
    logic        o_release_valid;
    logic [15:0] o_release_base;
    logic [16:0] o_release_bytes;

    slab_size_class_allocator u_dut (.*);

    // Predictor state.
    logic [16:0] heads [ssca_pkg::NUM_CLASSES];
    logic [16:0] links [ssca_pkg::NUM_LINKS];
    logic [3:0]  tags  [ssca_pkg::NUM_PAGES];
    t_resp       expected_q [$];
    // Addresses currently handed out, so frees can return them.
    logic [15:0] live_q [$];

    int errors;
    int cycles;
    int words_sent;
    int words_checked;
    int send_idle_pct;
    int recv_idle_pct;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Cycle limit guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver stall pattern.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Compare each accepted output word against the oldest prediction.
    always @(posedge i_clk) begin
        t_resp e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                $error("output word with nothing expected");
                errors++;
            end else begin
                e = expected_q.pop_front();
                words_checked++;
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status);
                    errors++;
                end
                if (o_result_addr !== e.addr) begin
                    $error("result_addr exp %h got %h", e.addr, o_result_addr);
                    errors++;
                end
                if (o_grant_used !== e.used) begin
                    $error("grant_used exp %0d got %0d", e.used, o_grant_used);
                    errors++;
                end
                if (o_release_valid !== e.rel_valid) begin
                    $error("release_valid exp %0d got %0d", e.rel_valid, o_release_valid);
                    errors++;
                end
                if (o_release_base !== e.rel_base) begin
                    $error("release_base exp %h got %h", e.rel_base, o_release_base);
                    errors++;
                end
                if (o_release_bytes !== e.rel_bytes) begin
                    $error("release_bytes exp %0d got %0d", e.rel_bytes, o_release_bytes);
                    errors++;
                end
            end
        end
    end

    function automatic logic [3:0] size_class(input logic [16:0] size);
        logic [3:0] c;
        logic [16:0] v;
        int n;
        if (size <= ssca_pkg::TABLE_LIMIT) begin
            case ((size - 1) / 8)
                0: c = 4'd3;
                1: c = 4'd4;
                2, 3: c = 4'd5;
                4, 5, 6, 7: c = 4'd6;
                8, 9, 10, 11: c = 4'd1;
                12, 13, 14, 15: c = 4'd7;
                default: c = 4'd2;
            endcase
        end else begin
            v = size - 17'd1;
            n = 0;
            while (v != 0) begin
                n++;
                v >>= 1;
            end
            c = n[3:0];
        end
        return c;
    endfunction

    function automatic int object_bytes(input logic [3:0] c);
        if (c == 4'd1) return 96;
        if (c == 4'd2) return 192;
        return 1 << c;
    endfunction

    // Works out the response to one word and updates the allocator copy.
    function automatic t_resp predict_alloc_free(input logic kind, input logic [16:0] size,
            input logic [15:0] faddr, input logic gok, input logic [15:0] gbase_in);
        t_resp r;
        logic [3:0] c;
        logic [16:0] head;
        logic [15:0] gbase;
        logic [15:0] a;
        int sz, n, pages, first, p, bytes, pg;
        r = '0;
        gbase = {gbase_in[15:12], 12'd0};
        if (kind == ssca_pkg::REQ_ALLOC) begin
            if (size == 0) begin
                r.status = ssca_pkg::ST_ZERO;
                r.addr = 16'(ssca_pkg::ZERO_MARK);
            end else if (size <= ssca_pkg::MAX_CLASS_BYTES) begin
                c = size_class(size);
                head = heads[c];
                if (!head[16]) begin
                    if (!gok) begin
                        r.status = ssca_pkg::ST_OOM;
                        return r;
                    end
                    sz = object_bytes(c);
                    n = ssca_pkg::PAGE_BYTES / sz;
                    for (int k = 0; k < n; k++) begin
                        a = 16'(gbase + k * sz);
                        links[a >> 3] = (k + 1 < n) ? {1'b1, 16'(a + sz)} : head;
                    end
                    tags[gbase[15:12]] = c;
                    head = {1'b1, gbase};
                    r.used = 1'b1;
                end
                a = head[15:0];
                heads[c] = links[a >> 3];
                r.addr = a;
            end else begin
                pages = (size + ssca_pkg::PAGE_BYTES - 1) / ssca_pkg::PAGE_BYTES;
                first = int'(gbase[15:12]);
                if (!gok || first + pages > ssca_pkg::NUM_PAGES) begin
                    r.status = ssca_pkg::ST_OOM;
                    return r;
                end
                tags[first] = ssca_pkg::TAG_FIRST;
                for (int k = 1; k < pages; k++) tags[first + k] = ssca_pkg::TAG_CONT;
                r.addr = gbase;
                r.used = 1'b1;
            end
        end else begin
            pg = int'(faddr[15:12]);
            if (faddr == ssca_pkg::ZERO_MARK) return r;
            if (tags[pg] == ssca_pkg::TAG_FIRST) begin
                bytes = ssca_pkg::PAGE_BYTES;
                p = pg + 1;
                while (p < ssca_pkg::NUM_PAGES && tags[p] == ssca_pkg::TAG_CONT) begin
                    bytes += ssca_pkg::PAGE_BYTES;
                    p++;
                end
                r.rel_valid = 1'b1;
                r.rel_base = {faddr[15:12], 12'd0};
                r.rel_bytes = 17'(bytes);
            end else if (tags[pg] >= 1 && tags[pg] <= ssca_pkg::TAG_LAST_CLASS) begin
                links[faddr >> 3] = heads[tags[pg]];
                heads[tags[pg]] = {1'b1, faddr};
            end
        end
        return r;
    endfunction

    // Sends one word, records the prediction and waits for acceptance.
    // Valid stays high after acceptance; the next word or drain changes it.
    task automatic send_word(input logic kind, input logic [16:0] size,
            input logic [15:0] faddr, input logic gok, input logic [15:0] gbase);
        t_resp r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= kind;
        i_req_size   <= size;
        i_free_addr  <= faddr;
        i_grant_ok   <= gok;
        i_grant_base <= gbase;
        r = predict_alloc_free(kind, size, faddr, gok, gbase);
        if (kind == ssca_pkg::REQ_ALLOC && r.status == ssca_pkg::ST_OK
            && size <= ssca_pkg::MAX_CLASS_BYTES)
            live_q.push_back(r.addr);
        expected_q.push_back(r);
        words_sent++;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    // Picks a free page base, preferring pages whose tag is still clear.
    function automatic logic [15:0] pick_page();
        logic [3:0] p;
        for (int t = 0; t < 8; t++) begin
            p = 4'($urandom_range(15));
            if (tags[p] == 4'd0) return {p, 12'h000} | 16'($urandom_range(4095));
        end
        return 16'($urandom);
    endfunction

    task automatic test_directed;
        send_word(ssca_pkg::REQ_ALLOC, 17'd0, 16'hFFFF, 1'b1, 16'h0000);
        send_word(ssca_pkg::REQ_ALLOC, 17'd1, 16'h0000, 1'b0, 16'h0000);
        send_word(ssca_pkg::REQ_ALLOC, 17'd1, 16'h0000, 1'b1, 16'h0FFF);
        send_word(ssca_pkg::REQ_ALLOC, 17'd8, 16'h0000, 1'b1, 16'h1000);
        send_word(ssca_pkg::REQ_ALLOC, 17'd96, 16'h0000, 1'b1, 16'h2000);
        send_word(ssca_pkg::REQ_ALLOC, 17'd192, 16'h0000, 1'b1, 16'h3000);
        send_word(ssca_pkg::REQ_ALLOC, 17'd100, 16'h0000, 1'b1, 16'h4000);
        send_word(ssca_pkg::REQ_ALLOC, 17'd193, 16'h0000, 1'b1, 16'h5000);
        send_word(ssca_pkg::REQ_ALLOC, 17'd4096, 16'h0000, 1'b1, 16'h6000);
        send_word(ssca_pkg::REQ_ALLOC, 17'd4097, 16'h0000, 1'b1, 16'h7000);
        send_word(ssca_pkg::REQ_ALLOC, 17'd65536, 16'h0000, 1'b1, 16'h0000);
        send_word(ssca_pkg::REQ_ALLOC, 17'd8192, 16'h0000, 1'b1, 16'hF000);
        send_word(ssca_pkg::REQ_ALLOC, 17'd8192, 16'h0000, 1'b0, 16'h9000);
        send_word(ssca_pkg::REQ_ALLOC, 17'h1FFFF, 16'h0000, 1'b1, 16'h0000);
        send_word(ssca_pkg::REQ_FREE, 17'h1FFFF, 16'd16, 1'b1, 16'hFFFF);
        send_word(ssca_pkg::REQ_FREE, 17'd0, 16'h7000, 1'b0, 16'h0000);
        send_word(ssca_pkg::REQ_FREE, 17'd0, 16'h8000, 1'b0, 16'h0000);
        send_word(ssca_pkg::REQ_FREE, 17'd0, 16'hE000, 1'b0, 16'h0000);
        send_word(ssca_pkg::REQ_FREE, 17'd0, 16'h1003, 1'b0, 16'h0000);
        send_word(ssca_pkg::REQ_ALLOC, 17'd8, 16'h0000, 1'b0, 16'h0000);
        send_word(ssca_pkg::REQ_FREE, 17'd0, 16'h4060, 1'b0, 16'h0000);
        send_word(ssca_pkg::REQ_ALLOC, 17'd100, 16'h0000, 1'b0, 16'h0000);
        live_q.delete();
        drain();
    endtask

    // Mostly alloc/free pairs of live objects, with some noise.
    task automatic test_random(input int count);
        int sel, idx;
        logic [16:0] size;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            if (sel < 40) begin
                size = (sel < 30) ? 17'($urandom_range(1, 256))
                                  : 17'($urandom_range(1, 4096));
                send_word(ssca_pkg::REQ_ALLOC, size, 16'($urandom),
                          $urandom_range(9) != 0, pick_page());
            end else if (sel < 75 && live_q.size() != 0) begin
                idx = $urandom_range(live_q.size() - 1);
                send_word(ssca_pkg::REQ_FREE, 17'($urandom), live_q[idx],
                          1'($urandom), 16'($urandom));
                live_q.delete(idx);
            end else if (sel < 85) begin
                send_word(ssca_pkg::REQ_ALLOC, 17'($urandom_range(4097, 65536)),
                          16'($urandom), $urandom_range(4) != 0, 16'($urandom));
            end else if (sel < 95) begin
                // Frees of page bases hit large runs and raw tags.
                send_word(ssca_pkg::REQ_FREE, 17'($urandom),
                          {4'($urandom), 12'($urandom_range(1) ? 0 : $urandom)},
                          1'($urandom), 16'($urandom));
            end else begin
                send_word(ssca_pkg::REQ_ALLOC, 17'($urandom_range(1) ? 0 : $urandom),
                          16'($urandom), 1'($urandom), 16'($urandom));
            end
        end
    endtask

    task automatic test_idle_then_burst;
        test_random(40);
        // Hold off until everything is back, then resume.
        drain();
        test_random(40);
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        words_sent = 0;
        words_checked = 0;
        send_idle_pct = 36;
        recv_idle_pct = 47;
        for (int k = 0; k < ssca_pkg::NUM_CLASSES; k++) heads[k] = '0;
        for (int k = 0; k < ssca_pkg::NUM_PAGES; k++) tags[k] = '0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_req_type = 1'b0;
        i_req_size = '0;
        i_free_addr = '0;
        i_grant_ok = 1'b0;
        i_grant_base = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(420);
        send_idle_pct = 47;
        recv_idle_pct = 36;
        test_random(420);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_idle_then_burst();
        test_random(400);
        drain();

        $display("Sent %0d words, checked %0d responses: size classes, carving, large runs,",
                 words_sent, words_checked);
        $display("frees of live objects, large releases and ignored frees under idling.");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
